@@ sv/upra_pkg.sv @@
package upra_pkg;

    // field and register widths
    localparam int SIDE_W    = 1;
    localparam int ECHO_W    = 16;
    localparam int CNT_W     = 7;
    localparam int OFS_W     = 14;
    localparam int GAP_W     = 16;
    localparam int DIST_W    = 18;
    localparam int DIFF_W    = 19;
    localparam int ANG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // distance arithmetic: raw = round(sum * 6304 / (n * 3625))
    localparam int SUM_W     = 22;
    localparam int NUM_W     = 35;
    localparam int DEN_W     = 18;
    localparam int QUO_W     = 23;
    localparam int REM_W     = 19;
    localparam int DCAND_W   = 25;
    localparam int DIST_MUL  = 6304;
    localparam int DIST_DIV  = 3625;
    localparam int N_MIN     = 1;
    localparam int N_MAX     = 64;
    localparam int DIST_MAX  = 131071;
    localparam int DIST_MIN  = -131072;

    // cordic
    localparam int ANGLE_ITER_DEF = 16;
    localparam int ATAN_STEPS     = 24;
    localparam int ATAN_W         = 22;
    localparam int CORDIC_SCALE   = 20;
    localparam int CW             = 42;
    localparam int Z_W            = 25;
    localparam int STEP_W         = 5;
    localparam int ANGLE_LIMIT    = 23040;

    // reset values of the registers
    localparam int SAMPLE_COUNT_RST = 8;
    localparam int SENSOR_GAP_RST   = 1536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_OFFSET_LEFT  = 2'd1,
        CFG_OFFSET_RIGHT = 2'd2,
        CFG_SENSOR_GAP   = 2'd3
    } t_cfg_idx;

    // atan(2^-i) in 1/65536 degree
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/ultrasonic_pair_range_angle_core.sv @@
// channel   valid         ready         payload
// input     i_in_valid    o_in_ready    i_side, i_echo_us
// output    o_out_valid   i_out_ready   o_side_done, o_distance, o_difference,
//                                       o_angle, o_angle_valid
// config    i_cfg_valid   o_cfg_ready   i_cfg_index, i_cfg_data
//
// a request that does not complete a reading only adds to the running sum and count
// a completed reading runs the multiply and the 23 step restoring divider; a right
//   one then runs ANGLE_ITERATIONS cordic steps (capped at 24), or none when the
//   difference or the gap is zero; divider and cordic pass share one step counter
// o_in_ready is low while a reading is being converted
// a held result in the output register stalls only the next completed reading
// synchronous active-low reset; config writes are always taken
module ultrasonic_pair_range_angle_core
    import upra_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [SIDE_W-1:0]           i_side,
    input  logic [ECHO_W-1:0]           i_echo_us,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [SIDE_W-1:0]           o_side_done,
    output logic signed [DIST_W-1:0]    o_distance,
    output logic signed [DIFF_W-1:0]    o_difference,
    output logic signed [ANG_W-1:0]     o_angle,
    output logic                        o_angle_valid,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DAT_W-1:0]        i_cfg_data
);

    localparam int CSTEPS = (ANGLE_ITERATIONS > ATAN_STEPS) ? ATAN_STEPS : ANGLE_ITERATIONS;
    localparam logic [STEP_W-1:0] CORD_LAST = STEP_W'(CSTEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);
    localparam logic signed [DCAND_W-1:0] D_MAX = DCAND_W'(DIST_MAX);
    localparam logic signed [DCAND_W-1:0] D_MIN = DCAND_W'(DIST_MIN);
    localparam logic signed [Z_W-1:0] Z_RND = Z_W'(128);
    localparam logic signed [Z_W-1:0] Z_LIM = Z_W'(ANGLE_LIMIT);
    localparam logic signed [Z_W-1:0] Z_NLIM = -Z_W'(ANGLE_LIMIT);
    localparam logic signed [ANG_W-1:0] A_LIM = ANG_W'(ANGLE_LIMIT);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MUL   = 10'b00_0000_0010,
        S_PREP  = 10'b00_0000_0100,
        S_DIV   = 10'b00_0000_1000,
        S_DIST  = 10'b00_0001_0000,
        S_DIFF  = 10'b00_0010_0000,
        S_CINIT = 10'b00_0100_0000,
        S_CORD  = 10'b00_1000_0000,
        S_ANG   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    // config registers
    logic [CNT_W-1:0]        r_sample_count;
    logic signed [OFS_W-1:0] r_offset_left;
    logic signed [OFS_W-1:0] r_offset_right;
    logic [GAP_W-1:0]        r_sensor_gap;

    // accumulation state
    t_state                  r_state;
    logic [SUM_W-1:0]        r_sum;
    logic [CNT_W-1:0]        r_cnt;
    logic [SIDE_W-1:0]       r_side;
    logic signed [DIST_W-1:0] r_left;

    // datapath
    logic [NUM_W-1:0]        r_prod;
    logic [DEN_W-1:0]        r_den;
    logic [REM_W-1:0]        r_rem;
    logic [QUO_W-1:0]        r_quo;
    logic [STEP_W-1:0]       r_step;
    logic signed [DIST_W-1:0] r_dist;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [CW-1:0]    r_x;
    logic signed [CW-1:0]    r_y;
    logic signed [Z_W-1:0]   r_z;
    logic signed [ANG_W-1:0] r_angle;

    // output register
    logic                    r_out_valid;
    logic [SIDE_W-1:0]       r_o_side;
    logic signed [DIST_W-1:0] r_o_dist;
    logic signed [DIFF_W-1:0] r_o_diff;
    logic signed [ANG_W-1:0] r_o_angle;

    logic                    w_acc;
    logic                    w_same;
    logic [CNT_W-1:0]        w_n;
    logic [SUM_W-1:0]        w_sum_new;
    logic [CNT_W-1:0]        w_cnt_new;
    logic [NUM_W-1:0]        w_num;
    logic [REM_W-1:0]        w_trial;
    logic                    w_qbit;
    logic signed [DCAND_W-1:0] w_dcand;
    logic signed [DIST_W-1:0] w_dsat;
    logic                    w_neg;
    logic [DIFF_W-1:0]       w_mag;
    logic signed [CW-1:0]    w_xs;
    logic signed [CW-1:0]    w_ys;
    logic                    w_ypos;
    logic signed [Z_W-1:0]   w_atan;
    logic signed [Z_W-1:0]   w_zr;
    logic signed [Z_W-1:0]   w_zsat;
    logic                    w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_sample_count < CNT_W'(N_MIN)) begin
            w_n = CNT_W'(N_MIN);
        end else if (r_sample_count > CNT_W'(N_MAX)) begin
            w_n = CNT_W'(N_MAX);
        end else begin
            w_n = r_sample_count;
        end
    end

    // a sample from the other side starts a fresh reading
    assign w_same    = (i_side == r_side);
    assign w_sum_new = (w_same ? r_sum : '0) + SUM_W'(i_echo_us);
    assign w_cnt_new = (w_same ? r_cnt : '0) + CNT_W'(1);

    // divider: num + den/2 for round half up, top bits seed the remainder
    assign w_num   = r_prod + NUM_W'(r_den >> 1);
    assign w_trial = {r_rem[REM_W-2:0], r_quo[QUO_W-1]};
    assign w_qbit  = (w_trial >= REM_W'(r_den));

    always_comb begin
        w_dcand = $signed({2'b00, r_quo})
                - $signed(DCAND_W'(r_side != '0 ? r_offset_right : r_offset_left));
        if (r_side == '0) begin
            w_dcand = $signed({2'b00, r_quo}) - DCAND_W'(r_offset_left);
        end else begin
            w_dcand = $signed({2'b00, r_quo}) - DCAND_W'(r_offset_right);
        end
        if (w_dcand > D_MAX) begin
            w_dsat = DIST_W'(D_MAX);
        end else if (w_dcand < D_MIN) begin
            w_dsat = DIST_W'(D_MIN);
        end else begin
            w_dsat = w_dcand[DIST_W-1:0];
        end
    end

    assign w_neg  = r_diff[DIFF_W-1];
    assign w_mag  = w_neg ? DIFF_W'(-r_diff) : DIFF_W'(r_diff);
    assign w_xs   = r_x >>> r_step;
    assign w_ys   = r_y >>> r_step;
    assign w_ypos = !r_y[CW-1] && (r_y != '0);
    assign w_atan = $signed({{(Z_W-ATAN_W){1'b0}}, atan_q16(r_step)});

    always_comb begin
        w_zr = (r_z + Z_RND) >>> 8;
        if (w_zr > Z_LIM) begin
            w_zsat = Z_LIM;
        end else if (w_zr < Z_NLIM) begin
            w_zsat = Z_NLIM;
        end else begin
            w_zsat = w_zr;
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= CNT_W'(SAMPLE_COUNT_RST);
            r_offset_left  <= '0;
            r_offset_right <= '0;
            r_sensor_gap   <= GAP_W'(SENSOR_GAP_RST);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[CNT_W-1:0];
                CFG_OFFSET_LEFT:  r_offset_left  <= $signed(i_cfg_data[OFS_W-1:0]);
                CFG_OFFSET_RIGHT: r_offset_right <= $signed(i_cfg_data[OFS_W-1:0]);
                CFG_SENSOR_GAP:   r_sensor_gap   <= i_cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // control and accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_side      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_side <= i_side;
                        r_sum  <= w_sum_new;
                        if (w_cnt_new >= w_n) begin
                            r_cnt   <= '0;
                            r_state <= S_MUL;
                        end else begin
                            r_cnt <= w_cnt_new;
                        end
                    end
                end
                S_MUL: begin
                    r_sum   <= '0;
                    r_state <= S_PREP;
                end
                S_PREP:  r_state <= S_DIV;
                S_DIV: begin
                    if (r_step == DIV_LAST) begin
                        r_state <= S_DIST;
                    end
                end
                S_DIST: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    if (r_side == '0) begin
                        r_left  <= r_dist;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CINIT;
                    end
                end
                S_CINIT: begin
                    if (r_diff == '0 || r_sensor_gap == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (r_step == CORD_LAST) begin
                        r_state <= S_ANG;
                    end
                end
                S_ANG:   r_state <= S_OUT;
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL: begin
                r_prod <= NUM_W'(r_sum) * NUM_W'(DIST_MUL);
                r_den  <= DEN_W'(w_n) * DEN_W'(DIST_DIV);
            end
            S_PREP: begin
                r_rem  <= REM_W'(w_num[NUM_W-1:QUO_W]);
                r_quo  <= w_num[QUO_W-1:0];
                r_step <= '0;
            end
            S_DIV: begin
                // quotient bits shift in as numerator bits shift out
                r_rem  <= w_qbit ? (w_trial - REM_W'(r_den)) : w_trial;
                r_quo  <= {r_quo[QUO_W-2:0], w_qbit};
                r_step <= r_step + STEP_W'(1);
            end
            S_DIST: begin
                r_dist <= w_dsat;
            end
            S_DIFF: begin
                r_diff  <= $signed({r_left[DIST_W-1], r_left})
                         - $signed({r_dist[DIST_W-1], r_dist});
                r_angle <= '0;
            end
            S_CINIT: begin
                if (r_diff == '0) begin
                    r_angle <= '0;
                end else begin
                    r_angle <= w_neg ? -A_LIM : A_LIM;
                end
                r_x    <= $signed({{(CW-GAP_W-CORDIC_SCALE){1'b0}}, r_sensor_gap,
                                   {CORDIC_SCALE{1'b0}}});
                r_y    <= $signed({{(CW-DIFF_W-CORDIC_SCALE){1'b0}}, w_mag,
                                   {CORDIC_SCALE{1'b0}}});
                r_z    <= '0;
                r_step <= '0;
            end
            S_CORD: begin
                if (w_ypos) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_atan;
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_atan;
                end
                r_step <= r_step + STEP_W'(1);
            end
            S_ANG: begin
                r_angle <= w_neg ? -ANG_W'(w_zsat) : ANG_W'(w_zsat);
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_o_side  <= r_side;
                    r_o_dist  <= r_dist;
                    r_o_diff  <= (r_side == '0) ? '0 : r_diff;
                    r_o_angle <= (r_side == '0) ? '0 : r_angle;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_side_done   = r_o_side;
    assign o_distance    = r_o_dist;
    assign o_difference  = r_o_diff;
    assign o_angle       = r_o_angle;
    assign o_angle_valid = r_o_side[0];

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIST) |-> (r_rem < REM_W'(r_den)))
        else $error("divider remainder not below divisor");

    a_left_no_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_angle_valid) |-> (o_difference == '0 && o_angle == '0))
        else $error("left reading carries difference or angle");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_angle <= A_LIM && o_angle >= -A_LIM))
        else $error("angle out of range");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded into output register");
`endif

endmodule
